>>> rtl/pidsc_pkg.sv
// shared widths, register map and configuration type for the speed pid controller
package pidsc_pkg;

	// field widths
	localparam int SPEED_WIDTH = 24;
	localparam int SUM_WIDTH   = 48;
	localparam int GAIN_W      = 32;
	localparam int PERIOD_W    = 16;
	localparam int DRIVE_W     = 24;
	localparam int BAND_W      = 23;
	localparam int COUNT_W     = 8;
	localparam int FRAC_W      = 16;

	// error and error difference
	localparam int ERR_W = SPEED_WIDTH + 1;
	localparam int DE_W  = SPEED_WIDTH + 2;

	// serial multiplier: multiplier operand padded to an even number of bits
	localparam int MUL_B_RAW = (SUM_WIDTH > DE_W) ? SUM_WIDTH : DE_W;
	localparam int MUL_B_W   = MUL_B_RAW + (MUL_B_RAW % 2);
	localparam int MUL_P_W   = GAIN_W + MUL_B_W;
	localparam int MUL_STEPS = MUL_B_W / 2;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

	// serial divider for the derivative term, magnitude of gain times difference
	localparam int DPROD_W   = GAIN_W + DE_W;
	localparam int DIV_N_RAW = DPROD_W - 2;
	localparam int DIV_N_W   = DIV_N_RAW + (DIV_N_RAW % 2);
	localparam int DIV_STEPS = DIV_N_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// integral term saturates at +-2^ISAT_LIM, total wide enough for all three terms
	localparam int ISAT_LIM = 60;
	localparam int TERM_MAX = (ISAT_LIM > DIV_N_W) ? ISAT_LIM : DIV_N_W;
	localparam int TOTAL_W  = TERM_MAX + 3;

	// configuration port
	localparam int REG_IDX_W  = 3;
	localparam int APB_ADDR_W = REG_IDX_W + 2;
	localparam int APB_DATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_MIN     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BAND_WIDTH    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_FREEZE_AFTER  = 3'd7;

	// command codes
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_prop;
		logic [GAIN_W-1:0]   gain_integ;
		logic [GAIN_W-1:0]   gain_deriv;
		logic [PERIOD_W-1:0] sample_period;
		logic [DRIVE_W-1:0]  drive_min;
		logic [DRIVE_W-1:0]  drive_max;
		logic [BAND_W-1:0]   band_width;
		logic [COUNT_W-1:0]  freeze_after;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_prop:     '0,
		gain_integ:    '0,
		gain_deriv:    '0,
		sample_period: 16'd655,
		drive_min:     24'h800000,
		drive_max:     24'h7FFFFF,
		band_width:    23'd512,
		freeze_after:  8'd10
	};

endpackage

>>> rtl/pidsc_in_if.sv
// command channel: valid/ready with one step or clear command per beat
interface pidsc_in_if;
	import pidsc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [SPEED_WIDTH-1:0] measured_speed;
	logic signed [SPEED_WIDTH-1:0] target_speed;

	modport source (output valid, command, measured_speed, target_speed, input ready);
	modport sink   (input valid, command, measured_speed, target_speed, output ready);

endinterface

>>> rtl/pidsc_out_if.sv
// result channel: valid/ready with one drive value per beat
interface pidsc_out_if;
	import pidsc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      frozen;

	modport source (output valid, drive, frozen, input ready);
	modport sink   (input valid, drive, frozen, output ready);

endinterface

>>> rtl/pidsc_regs.sv
// apb configuration registers of the speed pid controller
module pidsc_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pidsc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pidsc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pidsc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	output pidsc_pkg::cfg_t                   cfg
);
	import pidsc_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN_PROP:     cfg_q.gain_prop     <= pwdata[GAIN_W-1:0];
				REG_GAIN_INTEG:    cfg_q.gain_integ    <= pwdata[GAIN_W-1:0];
				REG_GAIN_DERIV:    cfg_q.gain_deriv    <= pwdata[GAIN_W-1:0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period <= pwdata[PERIOD_W-1:0];
				REG_DRIVE_MIN:     cfg_q.drive_min     <= pwdata[DRIVE_W-1:0];
				REG_DRIVE_MAX:     cfg_q.drive_max     <= pwdata[DRIVE_W-1:0];
				REG_BAND_WIDTH:    cfg_q.band_width    <= pwdata[BAND_W-1:0];
				REG_FREEZE_AFTER:  cfg_q.freeze_after  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		unique case (idx)
			REG_GAIN_PROP:     prdata = APB_DATA_W'(cfg_q.gain_prop);
			REG_GAIN_INTEG:    prdata = APB_DATA_W'(cfg_q.gain_integ);
			REG_GAIN_DERIV:    prdata = APB_DATA_W'(cfg_q.gain_deriv);
			REG_SAMPLE_PERIOD: prdata = APB_DATA_W'(cfg_q.sample_period);
			REG_DRIVE_MIN:     prdata = APB_DATA_W'(cfg_q.drive_min);
			REG_DRIVE_MAX:     prdata = APB_DATA_W'(cfg_q.drive_max);
			REG_BAND_WIDTH:    prdata = APB_DATA_W'(cfg_q.band_width);
			REG_FREEZE_AFTER:  prdata = APB_DATA_W'(cfg_q.freeze_after);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/pidsc_mul.sv
// signed shift-add multiplier taking two multiplier bits per cycle
module pidsc_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [pidsc_pkg::GAIN_W-1:0]   a,
	input  logic signed [pidsc_pkg::MUL_B_W-1:0]  b,
	output logic                                  done,
	output logic signed [pidsc_pkg::MUL_P_W-1:0]  product
);
	import pidsc_pkg::*;

	localparam int HI_W  = GAIN_W + 2;
	localparam int ACC_W = GAIN_W + 4;

	logic                     busy_q;
	logic                     done_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic signed [GAIN_W-1:0] a_q;
	logic signed [HI_W-1:0]   hi_q;
	logic [MUL_B_W-1:0]       lo_q;

	logic                     last;
	logic signed [ACC_W-1:0]  a_ext;
	logic signed [ACC_W-1:0]  a_dbl;
	logic signed [ACC_W-1:0]  term0;
	logic signed [ACC_W-1:0]  term1;
	logic signed [ACC_W-1:0]  acc;
	logic [HI_W+MUL_B_W-1:0]  full;

	// one radix-4 digit: low bit adds a, high bit adds 2a, or takes 2a off for the sign digit
	always_comb begin
		last  = (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
		a_ext = ACC_W'(a_q);
		a_dbl = a_ext <<< 1;
		term0 = lo_q[0] ? a_ext : '0;
		if (lo_q[1]) begin
			term1 = last ? -a_dbl : a_dbl;
		end else begin
			term1 = '0;
		end
		acc = ACC_W'(hi_q) + term0 + term1;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + MUL_CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial product shifts right two bits a step, multiplier bits leave at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= acc[ACC_W-1:2];
			lo_q <= {acc[1:0], lo_q[MUL_B_W-1:2]};
		end
	end

	assign full    = {hi_q, lo_q};
	assign product = full[MUL_P_W-1:0];
	assign done    = done_q;

endmodule

>>> rtl/pidsc_div.sv
// unsigned restoring divider taking two quotient bits per cycle
module pidsc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pidsc_pkg::DIV_N_W-1:0]       dividend,
	input  logic [pidsc_pkg::PERIOD_W-1:0]      divisor,
	output logic                                done,
	output logic [pidsc_pkg::DIV_N_W-1:0]       quotient,
	output logic                                rem_zero
);
	import pidsc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   n_q;
	logic [PERIOD_W-1:0]  r_q;
	logic [PERIOD_W-1:0]  d_q;

	logic                 last;
	logic [PERIOD_W:0]    r1;
	logic [PERIOD_W:0]    r1s;
	logic [PERIOD_W:0]    r2;
	logic [PERIOD_W:0]    r2s;
	logic                 ge1;
	logic                 ge2;

	// two chained compare and subtract steps
	always_comb begin
		last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		r1   = {r_q, n_q[DIV_N_W-1]};
		ge1  = (r1 >= {1'b0, d_q});
		r1s  = ge1 ? (r1 - {1'b0, d_q}) : r1;
		r2   = {r1s[PERIOD_W-1:0], n_q[DIV_N_W-2]};
		ge2  = (r2 >= {1'b0, d_q});
		r2s  = ge2 ? (r2 - {1'b0, d_q}) : r2;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			n_q <= {n_q[DIV_N_W-3:0], ge1, ge2};
			r_q <= r2s[PERIOD_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = n_q;
	assign rem_zero = (r_q == '0);

endmodule

>>> rtl/pid_speed_controller_deadband.sv
// Speed loop PID controller with error deadband freeze and output clamp. Each command
// beat on req is either a control step (error = target - measured) or a clear, which
// resets the error sum, previous error and in-band counter and gives no result beat.
// A control step whose error has stayed inside the band for more than freeze_after
// steps returns the held drive with frozen set. Any other step runs a full update:
// the three gain products come from serial multipliers taking two bits of the 48-bit
// operand per cycle, then the derivative division by sample_period runs through a
// serial divider at two quotient bits per cycle over a 56-bit magnitude, followed by
// the final sum and clamp. One command is in work at a time; a new command is taken
// as soon as the previous one has finished, even while its result still waits on rsp.
// sample_period of zero divides by one. Registers are written over apb at byte
// address 4*index; the user must write them only while the block is idle, as the
// block itself does not enforce it.
module pid_speed_controller_deadband (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pidsc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pidsc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pidsc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	pidsc_in_if.sink                          req,
	pidsc_out_if.source                       rsp
);
	import pidsc_pkg::*;

	localparam int CMP_W = ERR_W + BAND_W;
	localparam int ISH_W = MUL_P_W - FRAC_W;

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
	localparam logic signed [TOTAL_W-1:0] I_SAT_POS =
		{{(TOTAL_W-ISAT_LIM-1){1'b0}}, 1'b1, {ISAT_LIM{1'b0}}};
	localparam logic signed [TOTAL_W-1:0] I_SAT_NEG =
		{{(TOTAL_W-ISAT_LIM){1'b1}}, {ISAT_LIM{1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_GO,
		ST_MUL,
		ST_DIV,
		ST_ADD,
		ST_CLAMP,
		ST_PUT
	} state_t;

	cfg_t cfg;

	// controller state and output registers
	state_t                        state_q;
	logic signed [SUM_WIDTH-1:0]   error_sum_q;
	logic signed [ERR_W-1:0]       prev_err_q;
	logic [COUNT_W-1:0]            count_q;
	logic signed [DRIVE_W-1:0]     held_q;

	// datapath registers
	logic                          cmd_q;
	logic signed [SPEED_WIDTH-1:0] meas_q;
	logic signed [SPEED_WIDTH-1:0] targ_q;
	logic signed [ERR_W-1:0]       err_q;
	logic signed [DE_W-1:0]        de_q;
	logic signed [TOTAL_W-1:0]     p_term_q;
	logic signed [TOTAL_W-1:0]     i_term_q;
	logic signed [TOTAL_W-1:0]     pi_q;
	logic                          d_neg_q;
	logic signed [TOTAL_W-1:0]     d_term_q;
	logic signed [TOTAL_W-1:0]     total_q;
	logic signed [DRIVE_W-1:0]     result_q;
	logic                          put_frozen_q;

	// step evaluation
	logic signed [ERR_W-1:0]       err;
	logic [ERR_W-1:0]              mag;
	logic                          in_band;
	logic [COUNT_W-1:0]            count_inc;
	logic                          freeze;
	logic signed [SUM_WIDTH:0]     sum_wide;
	logic signed [SUM_WIDTH-1:0]   sum_sat;
	logic signed [DE_W-1:0]        de;

	// multiplier and divider hookup
	logic                          mul_start;
	logic                          done_p;
	logic                          done_i;
	logic                          done_d;
	logic                          mul_done;
	logic signed [MUL_P_W-1:0]     prod_p;
	logic signed [MUL_P_W-1:0]     prod_i;
	logic signed [MUL_P_W-1:0]     prod_d;
	logic signed [ISH_W-1:0]       i_shift;
	logic                          i_in_range;
	logic signed [TOTAL_W-1:0]     i_term;
	logic signed [DPROD_W-1:0]     dprod;
	logic [DPROD_W-1:0]            dmag;
	logic [PERIOD_W-1:0]           divisor;
	logic                          div_start;
	logic                          div_done;
	logic [DIV_N_W-1:0]            quotient;
	logic                          rem_zero;
	logic signed [TOTAL_W-1:0]     d_term;
	logic signed [TOTAL_W-1:0]     drv_hi;
	logic signed [TOTAL_W-1:0]     drv_lo;
	logic signed [TOTAL_W-1:0]     clamp_a;
	logic signed [TOTAL_W-1:0]     clamp_b;
	logic                          out_free;

	pidsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// error, deadband test and saturating error sum
	always_comb begin
		err       = ERR_W'(targ_q) - ERR_W'(meas_q);
		mag       = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		in_band   = (CMP_W'(mag) < CMP_W'(cfg.band_width));
		count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
		freeze    = in_band && (count_inc > cfg.freeze_after);
		sum_wide  = (SUM_WIDTH+1)'(error_sum_q) + (SUM_WIDTH+1)'(err);
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[SUM_WIDTH-1:0];
		end
		de = DE_W'(err) - DE_W'(prev_err_q);
	end

	// the three gain products
	assign mul_start = (state_q == ST_MUL_GO);
	assign mul_done  = done_p & done_i & done_d;

	pidsc_mul u_mul_p (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       ($signed(cfg.gain_prop)),
		.b       (MUL_B_W'(err_q)),
		.done    (done_p),
		.product (prod_p)
	);

	pidsc_mul u_mul_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       ($signed(cfg.gain_integ)),
		.b       (MUL_B_W'(error_sum_q)),
		.done    (done_i),
		.product (prod_i)
	);

	pidsc_mul u_mul_d (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       ($signed(cfg.gain_deriv)),
		.b       (MUL_B_W'(de_q)),
		.done    (done_d),
		.product (prod_d)
	);

	// integral term scaled and saturated, derivative product split into sign and magnitude
	always_comb begin
		i_shift    = prod_i[MUL_P_W-1:FRAC_W];
		i_in_range = (&i_shift[ISH_W-1:ISAT_LIM]) || !(|i_shift[ISH_W-1:ISAT_LIM]);
		if (i_in_range) begin
			i_term = TOTAL_W'(i_shift);
		end else begin
			i_term = i_shift[ISH_W-1] ? I_SAT_NEG : I_SAT_POS;
		end
		dprod   = prod_d[DPROD_W-1:0];
		dmag    = dprod[DPROD_W-1] ? DPROD_W'(-dprod) : DPROD_W'(dprod);
		divisor = (cfg.sample_period == '0) ? PERIOD_W'(1) : cfg.sample_period;
	end

	assign div_start = (state_q == ST_MUL) && mul_done;

	pidsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dmag[DIV_N_W-1:0]),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient),
		.rem_zero (rem_zero)
	);

	// floored quotient: negative values round down unless the division is exact
	always_comb begin
		if (d_neg_q) begin
			d_term = ~TOTAL_W'(quotient) + TOTAL_W'(rem_zero);
		end else begin
			d_term = TOTAL_W'(quotient);
		end
		drv_hi  = TOTAL_W'($signed(cfg.drive_max));
		drv_lo  = TOTAL_W'($signed(cfg.drive_min));
		clamp_a = (total_q > drv_hi) ? drv_hi : total_q;
		clamp_b = (clamp_a < drv_lo) ? drv_lo : clamp_a;
	end

	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !rsp.valid || rsp.ready;

	// sequencer, controller history and the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			error_sum_q <= '0;
			prev_err_q  <= '0;
			count_q     <= '0;
			held_q      <= '0;
			rsp.valid   <= 1'b0;
			rsp.drive   <= '0;
			rsp.frozen  <= 1'b0;
		end else begin
			// beat taken, unless a new one replaces it below
			if (rsp.valid && rsp.ready && (state_q != ST_PUT)) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (cmd_q == CMD_CLEAR) begin
						error_sum_q <= '0;
						prev_err_q  <= '0;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end else begin
						count_q <= in_band ? count_inc : '0;
						if (freeze) begin
							state_q <= ST_PUT;
						end else begin
							error_sum_q <= sum_sat;
							prev_err_q  <= err;
							state_q     <= ST_MUL_GO;
						end
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					held_q  <= clamp_b[DRIVE_W-1:0];
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						rsp.valid  <= 1'b1;
						rsp.drive  <= result_q;
						rsp.frozen <= put_frozen_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q  <= req.command;
			meas_q <= req.measured_speed;
			targ_q <= req.target_speed;
		end
		if (state_q == ST_EVAL) begin
			err_q        <= err;
			de_q         <= de;
			result_q     <= held_q;
			put_frozen_q <= 1'b1;
		end
		if (div_start) begin
			p_term_q <= TOTAL_W'(prod_p[MUL_P_W-1:FRAC_W]);
			i_term_q <= i_term;
			d_neg_q  <= dprod[DPROD_W-1];
		end
		if (state_q == ST_DIV) begin
			pi_q <= p_term_q + i_term_q;
			if (div_done) begin
				d_term_q <= d_term;
			end
		end
		if (state_q == ST_ADD) begin
			total_q <= pi_q + d_term_q;
		end
		if (state_q == ST_CLAMP) begin
			result_q     <= clamp_b[DRIVE_W-1:0];
			put_frozen_q <= 1'b0;
		end
	end

endmodule

>>> tb/tb_pid_speed_controller_deadband.sv
// self-checking testbench for the deadband speed pid controller
`timescale 1ns / 100ps

module tb_pid_speed_controller_deadband;
	import pidsc_pkg::*;

	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 100;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int RANDOM_PHASES   = 10;
	localparam int PHASE_BEATS     = 95;

	localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN     = 24'sh800000;
	localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX     = 24'sh7FFFFF;
	localparam logic signed [DRIVE_W-1:0]     DRIVE_LOWEST  = 24'sh800000;
	localparam logic signed [DRIVE_W-1:0]     DRIVE_HIGHEST = 24'sh7FFFFF;

	localparam longint TERM_LIMIT = longint'(1) << ISAT_LIM;
	localparam longint SUM_HIGH   = (longint'(1) << (SUM_WIDTH - 1)) - 1;
	localparam longint SUM_LOW    = -SUM_HIGH - 1;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic                      frozen;
	} drive_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pidsc_in_if  req_if();
	pidsc_out_if rsp_if();

	pid_speed_controller_deadband DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	// controller model state, configuration shadow and predictions
	cfg_t                      settings   = CFG_RESET;
	longint                    err_total  = 0;
	longint                    last_err   = 0;
	int                        band_steps = 0;
	logic signed [DRIVE_W-1:0] held_drive = '0;
	drive_beat_t               drive_expect_q [$];

	// run bookkeeping
	int cycle_count    = 0;
	int mismatch_count = 0;
	int cmd_beats      = 0;
	int clear_beats    = 0;
	int drive_beats    = 0;
	int frozen_beats   = 0;
	int reg_writes     = 0;
	int hold_asked     = 0;
	int hold_taken     = 0;
	bit source_idling  = 1'b1;
	bit sink_idling    = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d drive beats still owed", cycle_count,
				drive_expect_q.size());
			$display("tb_pid_speed_controller_deadband: done, errors");
			$finish;
		end
	end

	function automatic void note_mismatch(input string what, input logic signed [63:0] want,
		input logic signed [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s at cycle %0d: expected %0d, got %0d", what, cycle_count,
				want, got);
	endfunction

	function automatic logic signed [SPEED_WIDTH-1:0] clip_speed(input longint value);
		if (value > longint'(SPEED_MAX))
			return SPEED_MAX;
		if (value < longint'(SPEED_MIN))
			return SPEED_MIN;
		return value[SPEED_WIDTH-1:0];
	endfunction

	// floor(gain * operand / 2^16), held within +-2^60
	function automatic longint gain_term(input logic [GAIN_W-1:0] gain, input longint operand);
		logic signed [127:0] prod;
		prod = $signed(gain) * operand;
		prod = prod >>> FRAC_W;
		if (prod > TERM_LIMIT)
			return TERM_LIMIT;
		if (prod < -TERM_LIMIT)
			return -TERM_LIMIT;
		return longint'(prod);
	endfunction

	// advance the controller model by one accepted command
	function automatic void predict_drive(input logic cmd,
		input logic signed [SPEED_WIDTH-1:0] measured, input logic signed [SPEED_WIDTH-1:0] target);
		longint err, mag, p_term, i_term, d_term, num, divisor, total;
		if (cmd == CMD_CLEAR) begin
			err_total  = 0;
			last_err   = 0;
			band_steps = 0;
			return;
		end
		err = longint'(target) - longint'(measured);
		mag = (err < 0) ? -err : err;

		// deadband: count in-band steps, freeze once past the allowance
		if (mag < longint'(settings.band_width)) begin
			if (band_steps < 255)
				band_steps++;
			if (band_steps > int'(settings.freeze_after)) begin
				drive_expect_q.push_back('{drive: held_drive, frozen: 1'b1});
				return;
			end
		end else begin
			band_steps = 0;
		end

		// saturating error sum
		if (err > 0 && err_total > SUM_HIGH - err)
			err_total = SUM_HIGH;
		else if (err < 0 && err_total < SUM_LOW - err)
			err_total = SUM_LOW;
		else
			err_total += err;

		p_term  = gain_term(settings.gain_prop, err);
		i_term  = gain_term(settings.gain_integ, err_total);
		divisor = (settings.sample_period == '0) ? 1 : longint'(settings.sample_period);
		num     = longint'($signed(settings.gain_deriv)) * (err - last_err);
		d_term  = num / divisor;
		if (num % divisor != 0 && num < 0)
			d_term--;
		last_err = err;

		// upper clamp first, so crossed limits give drive_min
		total = p_term + i_term + d_term;
		if (total > longint'($signed(settings.drive_max)))
			total = longint'($signed(settings.drive_max));
		if (total < longint'($signed(settings.drive_min)))
			total = longint'($signed(settings.drive_min));
		held_drive = total[DRIVE_W-1:0];
		drive_expect_q.push_back('{drive: held_drive, frozen: 1'b0});
	endfunction

	// offer one command beat, predict once it is taken
	task automatic send_cmd(input logic cmd, input logic signed [SPEED_WIDTH-1:0] measured,
		input logic signed [SPEED_WIDTH-1:0] target);
		if (source_idling && $urandom_range(0, 4) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_if.valid          <= 1'b1;
		req_if.command        <= cmd;
		req_if.measured_speed <= measured;
		req_if.target_speed   <= target;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		cmd_beats++;
		if (cmd == CMD_CLEAR)
			clear_beats++;
		predict_drive(cmd, measured, target);
	endtask

	// control step with |error| below spread, random target
	task automatic send_near(input longint spread);
		logic signed [SPEED_WIDTH-1:0] target;
		longint offset;
		target = SPEED_WIDTH'($urandom);
		offset = (spread > 0) ? longint'($urandom_range(0, 32'(spread - 1))) : 0;
		if ($urandom_range(0, 1) == 1)
			offset = -offset;
		send_cmd(CMD_STEP, clip_speed(longint'(target) - offset), target);
	endtask

	// stop offering, wait for every drive beat, then let a clear finish
	task automatic settle();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (drive_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write then read back, shadow updated at the write
	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		reg_writes++;
		case (idx)
			REG_GAIN_PROP: begin
				settings.gain_prop = value;
				mask = 32'hFFFF_FFFF;
			end
			REG_GAIN_INTEG: begin
				settings.gain_integ = value;
				mask = 32'hFFFF_FFFF;
			end
			REG_GAIN_DERIV: begin
				settings.gain_deriv = value;
				mask = 32'hFFFF_FFFF;
			end
			REG_SAMPLE_PERIOD: begin
				settings.sample_period = value[PERIOD_W-1:0];
				mask = 32'h0000_FFFF;
			end
			REG_DRIVE_MIN: begin
				settings.drive_min = value[DRIVE_W-1:0];
				mask = 32'h00FF_FFFF;
			end
			REG_DRIVE_MAX: begin
				settings.drive_max = value[DRIVE_W-1:0];
				mask = 32'h00FF_FFFF;
			end
			REG_BAND_WIDTH: begin
				settings.band_width = value[BAND_W-1:0];
				mask = 32'h007F_FFFF;
			end
			default: begin
				settings.freeze_after = value[COUNT_W-1:0];
				mask = 32'h0000_00FF;
			end
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		// psel dropped before the next transfer
		@(posedge clk);
		if (((readback ^ value) & mask) != '0)
			note_mismatch("register readback", 64'(value & mask), 64'(readback & mask));
	endtask

	task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
		input logic [31:0] kd, input logic [15:0] period, input logic [23:0] lo,
		input logic [23:0] hi, input logic [22:0] band, input logic [7:0] freeze);
		settle();
		write_register(REG_GAIN_PROP, kp);
		write_register(REG_GAIN_INTEG, ki);
		write_register(REG_GAIN_DERIV, kd);
		write_register(REG_SAMPLE_PERIOD, 32'(period));
		write_register(REG_DRIVE_MIN, 32'(lo));
		write_register(REG_DRIVE_MAX, 32'(hi));
		write_register(REG_BAND_WIDTH, 32'(band));
		write_register(REG_FREEZE_AFTER, 32'(freeze));
	endtask

	// every register set to all ones then all zeros, each read back
	task automatic test_register_access();
		logic [REG_IDX_W-1:0] regs [$] = '{REG_GAIN_PROP, REG_GAIN_INTEG, REG_GAIN_DERIV,
			REG_SAMPLE_PERIOD, REG_DRIVE_MIN, REG_DRIVE_MAX, REG_BAND_WIDTH, REG_FREEZE_AFTER};
		foreach (regs[k])
			write_register(regs[k], 32'hFFFF_FFFF);
		foreach (regs[k])
			write_register(regs[k], 32'h0000_0000);
	endtask

	// speed extremes, band edges, freeze and clear
	task automatic test_directed_steps();
		load_settings(32'h0001_0000, 32'h0000_0100, 32'h0000_8000, 16'd655, DRIVE_LOWEST,
			DRIVE_HIGHEST, 23'd512, 8'd2);
		send_cmd(CMD_STEP, SPEED_MIN, SPEED_MAX);
		send_cmd(CMD_STEP, SPEED_MAX, SPEED_MIN);
		repeat (4) send_cmd(CMD_STEP, 0, 0);
		send_cmd(CMD_STEP, 0, 512);
		send_cmd(CMD_STEP, 0, -511);
		send_cmd(CMD_CLEAR, SPEED_MAX, SPEED_MIN);
		send_cmd(CMD_STEP, 100, 611);
		send_cmd(CMD_STEP, 0, -512);
		send_cmd(CMD_STEP, -1000, 2000);
		send_cmd(CMD_STEP, 5000, -3000);
	endtask

	// extreme gains, zero and full sample period, crossed limits, empty and full band
	task automatic test_config_corners();
		load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd0, 24'h000100,
			24'hFFFF00, 23'd0, 8'd0);
		send_cmd(CMD_STEP, SPEED_MIN, SPEED_MAX);
		send_cmd(CMD_STEP, 0, 0);
		send_cmd(CMD_STEP, SPEED_MAX, SPEED_MIN);
		load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, DRIVE_LOWEST,
			DRIVE_HIGHEST, 23'h7F_FFFF, 8'd0);
		send_cmd(CMD_STEP, 0, 100);
		send_cmd(CMD_STEP, 0, 8388607);
		send_cmd(CMD_STEP, SPEED_MIN, SPEED_MAX);
		send_cmd(CMD_STEP, -5, 5);
	endtask

	// in-band counter runs into its ceiling without freezing, then freezes at 254
	task automatic test_counter_saturation();
		load_settings(32'h0000_8000, 32'h0000_0010, 32'h0000_4000, 16'd655, 24'hF0_0000,
			24'h10_0000, 23'd4096, 8'd255);
		repeat (270) send_near(4096);
		settle();
		write_register(REG_FREEZE_AFTER, 32'd254);
		repeat (3) send_near(4096);
	endtask

	// long receiver hold-off with commands still offered, then a full drain
	task automatic test_backpressure();
		hold_asked++;
		repeat (12) send_cmd(CMD_STEP, SPEED_WIDTH'($urandom), SPEED_WIDTH'($urandom));
		settle();
	endtask

	task automatic apply_random_settings();
		logic [31:0]               gains [3];
		logic [15:0]               period;
		logic signed [DRIVE_W-1:0] lo, hi;
		logic [BAND_W-1:0]         band;
		logic [COUNT_W-1:0]        freeze;
		int                        limit;
		foreach (gains[g]) begin
			case ($urandom_range(0, 5))
				0:       gains[g] = '0;
				1:       gains[g] = 32'h7FFF_FFFF;
				2:       gains[g] = 32'h8000_0000;
				3:       gains[g] = $urandom;
				default: gains[g] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			endcase
		end
		case ($urandom_range(0, 5))
			0:       period = '0;
			1:       period = 16'd1;
			2:       period = 16'hFFFF;
			default: period = 16'($urandom_range(1, 2000));
		endcase
		case ($urandom_range(0, 4))
			0: begin
				lo = DRIVE_LOWEST;
				hi = DRIVE_HIGHEST;
			end
			1: begin
				lo = DRIVE_W'($urandom);
				hi = DRIVE_W'($urandom);
			end
			2: begin
				// crossed limits
				hi = DRIVE_W'($urandom_range(0, 32'h0000_FFFF));
				lo = DRIVE_W'(hi + $urandom_range(1, 4096));
			end
			default: begin
				limit = $urandom_range(256, 32'h007F_FFFF);
				lo = DRIVE_W'(-limit);
				hi = DRIVE_W'(limit);
			end
		endcase
		case ($urandom_range(0, 5))
			0:       band = '0;
			1:       band = '1;
			default: band = BAND_W'($urandom_range(0, 4096));
		endcase
		case ($urandom_range(0, 5))
			0:       freeze = '0;
			1:       freeze = 8'd254;
			2:       freeze = 8'd255;
			default: freeze = COUNT_W'($urandom_range(1, 12));
		endcase
		load_settings(gains[0], gains[1], gains[2], period, lo, hi, band, freeze);
	endtask

	// random settings per phase; mostly in-band runs, some band edges, wide steps, clears
	task automatic test_random_traffic();
		int     phase_end;
		int     pick;
		longint band;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			apply_random_settings();
			if (phase == RANDOM_PHASES - 1) begin
				source_idling = 1'b0;
				sink_idling   = 1'b0;
			end
			band      = longint'(settings.band_width);
			phase_end = cmd_beats + PHASE_BEATS;
			while (cmd_beats < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					send_cmd(CMD_CLEAR, SPEED_WIDTH'($urandom), SPEED_WIDTH'($urandom));
				end else if (pick < 6) begin
					settle();
				end else if (pick < 60) begin
					repeat ($urandom_range(1, 20))
						send_near(($urandom_range(0, 7) == 0) ? band + 2 : band);
				end else if (pick < 80) begin
					send_near(65536);
				end else begin
					send_cmd(CMD_STEP, SPEED_WIDTH'($urandom), SPEED_WIDTH'($urandom));
				end
			end
		end
	endtask

	// result side: random stall bursts, plus a long hold-off on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		stall_left   = 0;
		hold_left    = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_taken) begin
				hold_taken = hold_asked;
				hold_left  = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (sink_idling && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// compare each drive beat with the oldest prediction
	always @(posedge clk) begin : check_drive
		drive_beat_t want;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			drive_beats++;
			if (rsp_if.frozen === 1'b1)
				frozen_beats++;
			if (drive_expect_q.size() == 0) begin
				note_mismatch("drive beat with nothing predicted", 'x, 64'(rsp_if.drive));
			end else begin
				want = drive_expect_q.pop_front();
				if (rsp_if.drive !== want.drive)
					note_mismatch("drive", 64'(want.drive), 64'(rsp_if.drive));
				if (rsp_if.frozen !== want.frozen)
					note_mismatch("frozen", 64'(want.frozen), 64'(rsp_if.frozen));
			end
		end
	end

	initial begin
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		req_if.valid          = 1'b0;
		req_if.command        = CMD_STEP;
		req_if.measured_speed = '0;
		req_if.target_speed   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_steps();
		test_config_corners();
		test_counter_saturation();
		test_backpressure();
		test_random_traffic();
		settle();

		$display("covered %0d command beats (%0d clears) and %0d drive beats (%0d frozen)",
			cmd_beats, clear_beats, drive_beats, frozen_beats);
		$display("over %0d register writes, %0d mismatches", reg_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("tb_pid_speed_controller_deadband: done, clean");
		else
			$display("tb_pid_speed_controller_deadband: done, errors");
		$finish;
	end

endmodule
